FILE: hdl/lsbs_pkg.sv
// Package: shared types, constants and CORDIC table for the scan break segmenter.
`default_nettype none
package lsbs_pkg;
    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [1:0] ST_GOAL = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;
    localparam logic [1:0] ST_NOGOAL = 2'd3;
    localparam logic [2:0] REG_MAX = 3'd0;
    localparam logic [2:0] REG_MIN = 3'd1;
    localparam logic [2:0] REG_ASTART = 3'd2;
    localparam logic [2:0] REG_ASTEP = 3'd3;
    localparam logic [2:0] REG_BRK = 3'd4;
    localparam logic [2:0] REG_MINPTS = 3'd5;
    localparam logic [2:0] REG_LENLO = 3'd6;
    localparam logic [2:0] REG_LENHI = 3'd7;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_q30;
        logic signed [33:0] sin_q30;
    } t_cordic_rsp;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0: v = 34'sd536870912;
            5'd1: v = 34'sd316933406;
            5'd2: v = 34'sd167458907;
            5'd3: v = 34'sd85004756;
            5'd4: v = 34'sd42667331;
            5'd5: v = 34'sd21354465;
            5'd6: v = 34'sd10679838;
            5'd7: v = 34'sd5340245;
            5'd8: v = 34'sd2670163;
            5'd9: v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/lidar_scan_break_segmenter.sv
// Top level: range gate, sequencer, shared multiplier, region tracking and result store.
`default_nettype none
// A kept range sample passes from acceptance through the angle step, 24 CORDIC
// rotations and the steps through the single shared 34x18 multiplier before the
// input is ready again, and also through the close states when it closes the
// open region; a gated-out or ignored sample is handled in the idle state. End of
// scan closes the open region, then sends the result words, read from the region
// memory, while the sink takes them. The input is not ready while a word is in
// progress or results are being read out.
module lidar_scan_break_segmenter
    import lsbs_pkg::*;
#(
    parameter int MAX_POINTS  = 2048,
    parameter int MAX_REGIONS = 32,
    parameter int MIN_USEFUL  = 30
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // range[15:0]
    input  wire logic        s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // status, first, last, count, diag_sq, overflow
    output logic             m_axis_tlast,  // is_last
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int SW = $clog2(MAX_POINTS + 1);
    localparam int RW = $clog2(MAX_REGIONS + 1);
    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = (SW > 11) ? SW : 11;

    localparam logic [3:0] S_IDLE = 4'd0, S_ANG = 4'd1, S_CWAIT = 4'd2, S_MX = 4'd3,
        S_MY = 4'd4, S_DX = 4'd5, S_DY = 4'd6, S_UPD = 4'd7, S_CL0 = 4'd8, S_CL1 = 4'd9,
        S_CL2 = 4'd10, S_EOS = 4'd12, S_OUT = 4'd13, S_ORD = 4'd14;

    logic [3:0] r_st;
    logic r_eos;
    logic [15:0] r_max, r_min, r_brk, r_lo, r_hi;
    logic [31:0] r_astart, r_astep, r_ang;
    logic [10:0] r_minpts;
    logic [SW-1:0] r_sidx;
    logic [SW-1:0] r_useful;
    logic [15:0] r_range;
    logic signed [16:0] r_px, r_py, r_nx, r_ny, r_pendx, r_pendy;
    logic [SW-1:0] r_pendi;
    logic r_pendv;
    logic r_used;
    logic [SW-1:0] r_first, r_last, r_cnt;
    logic signed [16:0] r_xmin, r_xmax, r_ymin, r_ymax;
    logic [35:0] r_acc;
    logic r_brkflag;
    logic [RW-1:0] r_nst, r_rd;
    logic r_anyreg, r_ovf;
    logic [68:0] r_mem [MAX_REGIONS];
    logic [68:0] r_rdata;
    logic r_obusy;
    logic [71:0] r_odata;
    logic r_olast;

    // shared multiplier: signed 34 x 18
    logic signed [33:0] m_a;
    logic signed [17:0] m_b;
    logic signed [51:0] m_p;
    assign m_p = m_a * m_b;

    t_cordic_req creq;
    t_cordic_rsp crsp;
    lsbs_cordic u_cordic (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(creq), .o_rsp(crsp));

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    always_comb begin
        unique case (paddr[4:2])
            REG_MAX:    prdata = {16'd0, r_max};
            REG_MIN:    prdata = {16'd0, r_min};
            REG_ASTART: prdata = r_astart;
            REG_ASTEP:  prdata = r_astep;
            REG_BRK:    prdata = {16'd0, r_brk};
            REG_MINPTS: prdata = {21'd0, r_minpts};
            REG_LENLO:  prdata = {16'd0, r_lo};
            REG_LENHI:  prdata = {16'd0, r_hi};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 16'd1000; r_min <= 16'd20; r_astart <= '0; r_astep <= '0;
            r_brk <= 16'd50; r_minpts <= 11'd5; r_lo <= 16'd250; r_hi <= 16'd350;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_MAX:    r_max <= pwdata[15:0];
                REG_MIN:    r_min <= pwdata[15:0];
                REG_ASTART: r_astart <= pwdata;
                REG_ASTEP:  r_astep <= pwdata;
                REG_BRK:    r_brk <= pwdata[15:0];
                REG_MINPTS: r_minpts <= pwdata[10:0];
                REG_LENLO:  r_lo <= pwdata[15:0];
                REG_LENHI:  r_hi <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    // rounding and saturation of r*trig
    function automatic logic signed [16:0] sat_round(input logic signed [51:0] p);
        logic signed [51:0] v;
        v = (p + 52'sd536870912) >>> 30;
        if (v > 52'sd65535) return 17'sd65535;
        if (v < -52'sd65535) return -17'sd65535;
        return v[16:0];
    endfunction

    logic s_acc, m_acc, keep;
    assign s_axis_tready = (r_st == S_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign keep = (r_min < s_axis_tdata) && (s_axis_tdata < r_max);
    assign creq.start = (r_st == S_ANG);
    assign creq.angle = r_ang;

    logic signed [17:0] dxs, dys, wxs, wys;
    assign dxs = 18'(r_pendx) - 18'(r_px);
    assign dys = 18'(r_pendy) - 18'(r_py);
    assign wxs = 18'(r_xmax) - 18'(r_xmin);
    assign wys = 18'(r_ymax) - 18'(r_ymin);

    always_comb begin
        m_a = '0; m_b = '0;
        unique case (r_st)
            S_ANG:  begin m_a = 34'(signed'({1'b0, r_astep})); m_b = 18'sd0; end
            S_MX:   begin m_a = crsp.sin_q30; m_b = 18'(signed'({1'b0, r_range})); end
            S_MY:   begin m_a = crsp.cos_q30; m_b = 18'(signed'({1'b0, r_range})); end
            S_DX:   begin m_a = 34'(dxs); m_b = dxs; end
            S_DY:   begin m_a = 34'(dys); m_b = dys; end
            S_CL0:  begin m_a = 34'(wxs); m_b = wxs; end
            S_CL1:  begin m_a = 34'(wys); m_b = wys; end
            default: ;
        endcase
    end

    logic [35:0] diag;
    logic [31:0] lo2, hi2, brk2;
    assign diag = r_acc;
    assign lo2 = r_lo * r_lo;
    assign hi2 = r_hi * r_hi;
    assign brk2 = r_brk * r_brk;
    logic goal, region_ok;
    assign region_ok = r_used && (CW'(r_cnt) > CW'(r_minpts));
    assign goal = region_ok && ({4'd0, lo2} < diag) && (diag < {4'd0, hi2});

    logic out_free, eos_status, load_out;
    assign out_free = !r_obusy || m_acc;
    assign eos_status = (r_useful < SW'(MIN_USEFUL)) || !r_anyreg || (r_nst == '0);
    assign load_out = (((r_st == S_EOS) && eos_status) || (r_st == S_OUT)) && out_free;

    always_ff @(posedge i_clk) begin
        if (r_st == S_CL2 && goal && r_nst < RW'(MAX_REGIONS))
            r_mem[r_nst[AW-1:0]] <= {11'(r_first), 11'(r_last), 12'(r_cnt), diag[34:0]};
        if (r_st == S_EOS || r_st == S_ORD)
            r_rdata <= r_mem[r_rd[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_eos <= 1'b0;
            r_sidx <= '0; r_useful <= '0; r_pendv <= 1'b0; r_used <= 1'b0;
            r_nst <= '0; r_anyreg <= 1'b0; r_ovf <= 1'b0; r_obusy <= 1'b0;
            r_px <= '0; r_py <= '0; r_rd <= '0;
        end else begin
            if (load_out) r_obusy <= 1'b1;
            else if (m_acc) r_obusy <= 1'b0;
            unique case (r_st)
                S_IDLE: if (s_acc) begin
                    r_range <= s_axis_tdata;
                    if (s_axis_tuser) begin
                        r_eos <= 1'b1;
                        r_st <= S_CL0;
                    end else if (r_sidx < SW'(MAX_POINTS)) begin
                        if (keep) begin
                            r_ang <= r_astart + r_astep * (32'(r_sidx) - 32'd1);
                            r_st <= S_ANG;
                        end else r_sidx <= r_sidx + SW'(1);
                    end
                end
                S_ANG: r_st <= S_CWAIT;
                S_CWAIT: if (crsp.done) r_st <= S_MX;
                S_MX: begin r_nx <= sat_round(-m_p); r_st <= S_MY; end
                S_MY: begin r_ny <= sat_round(m_p); r_st <= S_DX; end
                S_DX: begin r_acc <= 36'(m_p); r_st <= S_DY; end
                S_DY: begin
                    r_brkflag <= (r_acc + 36'(m_p)) > {4'd0, brk2};
                    r_st <= S_UPD;
                end
                S_UPD: begin
                    if (r_pendv && r_used && r_brkflag) begin
                        // close the old region first, then come back here
                        r_eos <= 1'b0;
                        r_st <= S_CL0;
                    end else begin
                        if (r_pendv) begin
                            if (!r_used) begin
                                r_first <= r_pendi; r_last <= r_pendi; r_cnt <= SW'(1);
                                r_xmin <= r_pendx; r_xmax <= r_pendx;
                                r_ymin <= r_pendy; r_ymax <= r_pendy;
                                r_used <= 1'b1;
                            end else begin
                                r_last <= r_pendi; r_cnt <= r_cnt + SW'(1);
                                if (r_pendx < r_xmin) r_xmin <= r_pendx;
                                if (r_pendx > r_xmax) r_xmax <= r_pendx;
                                if (r_pendy < r_ymin) r_ymin <= r_pendy;
                                if (r_pendy > r_ymax) r_ymax <= r_pendy;
                            end
                            r_px <= r_pendx; r_py <= r_pendy;
                        end
                        r_pendv <= 1'b1; r_pendx <= r_nx; r_pendy <= r_ny;
                        r_pendi <= r_sidx;
                        r_useful <= r_useful + SW'(1);
                        r_sidx <= r_sidx + SW'(1);
                        r_st <= S_IDLE;
                    end
                end
                S_CL0: begin r_acc <= 36'(m_p); r_st <= S_CL1; end
                S_CL1: begin r_acc <= r_acc + 36'(m_p); r_st <= S_CL2; end
                S_CL2: begin
                    if (region_ok) r_anyreg <= 1'b1;
                    if (goal) begin
                        if (r_nst < RW'(MAX_REGIONS)) r_nst <= r_nst + RW'(1);
                        else r_ovf <= 1'b1;
                    end
                    r_used <= 1'b0;
                    if (r_eos) begin
                        r_rd <= '0; r_st <= S_EOS;
                    end else begin
                        r_st <= S_UPD;
                    end
                end
                S_EOS: begin
                    if (eos_status) begin
                        if (out_free) begin
                            r_odata <= {{70{1'b0}}, (r_useful < SW'(MIN_USEFUL)) ? ST_FEW :
                                        (!r_anyreg ? ST_NONE : ST_NOGOAL)};
                            r_olast <= 1'b1;
                            r_sidx <= '0; r_useful <= '0; r_pendv <= 1'b0; r_used <= 1'b0;
                            r_nst <= '0; r_anyreg <= 1'b0; r_ovf <= 1'b0;
                            r_px <= '0; r_py <= '0;
                            r_st <= S_IDLE;
                        end
                    end else begin
                        r_rd <= r_rd + RW'(1);
                        r_st <= S_OUT;
                    end
                end
                S_OUT: if (out_free) begin
                    r_odata <= {r_ovf, r_rdata[34:0], r_rdata[46:35], r_rdata[57:47],
                                r_rdata[68:58], ST_GOAL};
                    r_olast <= (r_rd == r_nst);
                    if (r_rd == r_nst) begin
                        r_sidx <= '0; r_useful <= '0; r_pendv <= 1'b0; r_used <= 1'b0;
                        r_nst <= '0; r_anyreg <= 1'b0; r_ovf <= 1'b0;
                        r_px <= '0; r_py <= '0;
                        r_st <= S_IDLE;
                    end else r_st <= S_ORD;
                end
                S_ORD: begin r_rd <= r_rd + RW'(1); r_st <= S_OUT; end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_obusy;
    assign m_axis_tdata = r_odata;
    assign m_axis_tlast = r_olast;

`ifndef ASSERT_OFF
    a_no_in_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !s_axis_tready) else $error("ready outside idle");
    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nst <= RW'(MAX_REGIONS)) else $error("region store overrun");
    a_useful_le_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_useful <= r_sidx) else $error("kept count exceeds sample index");
`endif
endmodule
`default_nettype wire

FILE: hdl/lsbs_cordic.sv
// Iterative CORDIC unit: one rotation per cycle, cosine and sine in Q30.
`default_nettype none
module lsbs_cordic
    import lsbs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cordic_req i_req,
    output t_cordic_rsp      o_rsp
);
    logic               r_busy, r_neg, r_done;
    logic [4:0]         r_step;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [33:0] dx, dy, at;
    logic [31:0]        a_adj;
    logic               neg;

    assign neg   = (i_req.angle[31:30] == 2'b01) || (i_req.angle[31:30] == 2'b10);
    assign a_adj = neg ? (i_req.angle ^ 32'h8000_0000) : i_req.angle;
    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;
    assign at = atan_entry(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= 34'(signed'(a_adj));
            r_neg <= neg;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.cos_q30 = r_neg ? -r_x : r_x;
    assign o_rsp.sin_q30 = r_neg ? -r_y : r_y;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("cordic done while busy");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step < 5'(CORDIC_STEPS)) else $error("cordic step overrun");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("cordic done held");
`endif
endmodule
`default_nettype wire
